[sv/gic_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gic_pkg
// Shared types and constants of the gamepad input conditioner.
// ----------------------------------------------------------------------------
package gic_pkg;

    // pad and stick constants
    localparam logic [7:0] KIND_ANALOG_A = 8'h05;
    localparam logic [7:0] KIND_ANALOG_B = 8'h07;
    localparam logic [7:0] STICK_CENTER  = 8'd128;
    localparam logic [7:0] STICK_MAX     = 8'd127;
    localparam logic [6:0] DZ_MAX        = 7'd126;
    localparam int         STICKS        = 4;
    localparam int         SEL_W         = 2;

    // rescale divider: 14-bit numerator (127 * 127), 7-bit divisor
    localparam int DIV_NUM_W = 14;
    localparam int DIV_DEN_W = 7;

    // func codes
    localparam logic FUNC_POLL  = 1'b0;
    localparam logic FUNC_CHECK = 1'b1;

    // controller -> datapath
    typedef struct packed {
        logic             load;         // latch the accepted word
        logic             div_start;    // start rescale of the selected stick
        logic             div_store;    // store the rescaled stick
        logic [SEL_W-1:0] stick_sel;    // stick being rescaled
        logic             mem_read;     // read history at the check index
        logic             commit_poll;  // update pad state, load result
        logic             commit_check; // update match state, maybe load result
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic is_check;
        logic player_ok;
        logic analog_conn;
        logic check_last;
        logic div_done;
        logic out_free;
    } status_t;

endpackage
`default_nettype wire

[sv/gic_divider.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gic_divider
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gic_divider (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic [gic_pkg::DIV_NUM_W-1:0] num,
    input  wire logic [gic_pkg::DIV_DEN_W-1:0] den,
    output logic                               done,
    output logic [gic_pkg::DIV_NUM_W-1:0]      quot
);
    import gic_pkg::*;

    localparam int CNT_W = $clog2(DIV_NUM_W + 1);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_NUM_W-1:0] quo_reg, quo_next;
    logic [DIV_DEN_W:0]   trial;
    logic                 fits;

    assign trial = {rem_reg, quo_reg[DIV_NUM_W-1]};
    assign fits  = trial >= {1'b0, den};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIV_NUM_W);
            rem_next  = '0;
            quo_next  = num;
        end
        else if (busy_reg)
        begin
            // remainder stays below den, so the difference fits DEN_W bits
            rem_next = fits ? DIV_DEN_W'(trial - {1'b0, den}) : trial[DIV_DEN_W-1:0];
            quo_next = {quo_reg[DIV_NUM_W-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign quot = quo_reg;

endmodule
`default_nettype wire

[sv/gic_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gic_ctrl
// Sequencer: accepts a word, steps the stick rescales, commits results.
// ----------------------------------------------------------------------------
module gic_ctrl (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire gic_pkg::status_t status,
    output gic_pkg::cmd_t         cmd
);
    import gic_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE      = 7'b0000001,
        ST_DISPATCH  = 7'b0000010,
        ST_DIV_START = 7'b0000100,
        ST_DIV_WAIT  = 7'b0001000,
        ST_POLL_FIN  = 7'b0010000,
        ST_CHECK_FIN = 7'b0100000,
        ST_SPARE     = 7'b1000000
    } state_t;

    state_t           state_reg, state_next;
    logic [SEL_W-1:0] stick_reg, stick_next;

    always_comb
    begin
        state_next = state_reg;
        stick_next = stick_reg;
        cmd        = '0;
        cmd.stick_sel = stick_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                if (status.is_check)
                begin
                    cmd.mem_read = 1'b1;
                    state_next   = ST_CHECK_FIN;
                end
                else if (!status.player_ok)
                    state_next = ST_IDLE;
                else if (status.analog_conn)
                begin
                    stick_next = '0;
                    state_next = ST_DIV_START;
                end
                else
                    state_next = ST_POLL_FIN;
            end
            ST_DIV_START:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (status.div_done)
                begin
                    cmd.div_store = 1'b1;
                    if (stick_reg == SEL_W'(STICKS - 1))
                        state_next = ST_POLL_FIN;
                    else
                    begin
                        stick_next = stick_reg + SEL_W'(1);
                        state_next = ST_DIV_START;
                    end
                end
            end
            ST_POLL_FIN:
            begin
                if (status.out_free)
                begin
                    cmd.commit_poll = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_CHECK_FIN:
            begin
                // a non-final compare element makes no result and never waits
                if (!status.check_last || status.out_free)
                begin
                    cmd.commit_check = 1'b1;
                    state_next       = ST_IDLE;
                end
            end
            ST_SPARE:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            stick_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            stick_reg <= stick_next;
        end
    end

endmodule
`default_nettype wire

[sv/gic_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gic_datapath
// Pad state, stick rescale, press history ring and result register.
// ----------------------------------------------------------------------------
module gic_datapath #(
    parameter int HISTORY_DEPTH = 32,
    parameter int PLAYERS       = 2
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire gic_pkg::cmd_t      cmd,
    output gic_pkg::status_t        status,
    input  wire logic               cfg_write_en,
    input  wire logic [6:0]         cfg_write_data,
    input  wire logic               func,
    input  wire logic               player,
    input  wire logic [7:0]         pad_status,
    input  wire logic [7:0]         pad_kind,
    input  wire logic [15:0]        buttons_raw,
    input  wire logic [7:0]         left_x_raw,
    input  wire logic [7:0]         left_y_raw,
    input  wire logic [7:0]         right_x_raw,
    input  wire logic [7:0]         right_y_raw,
    input  wire logic [4:0]         check_index,
    input  wire logic [15:0]        check_word,
    input  wire logic               check_last,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [15:0]             held_mask,
    output logic [15:0]             pressed_mask,
    output logic [15:0]             released_mask,
    output logic signed [7:0]       left_x,
    output logic signed [7:0]       left_y,
    output logic signed [7:0]       right_x,
    output logic signed [7:0]       right_y,
    output logic signed [7:0]       left_x_delta,
    output logic signed [7:0]       left_y_delta,
    output logic signed [7:0]       right_x_delta,
    output logic signed [7:0]       right_y_delta,
    output logic                    sequence_match
);
    import gic_pkg::*;

    localparam int PTR_W = $clog2(HISTORY_DEPTH);
    localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
    localparam int CMP_W = (CNT_W > 9) ? CNT_W : 9;
    localparam int PLY_W = (PLAYERS > 1) ? $clog2(PLAYERS) : 1;

    // ---- configuration ----
    logic [6:0] dz_cfg_reg;
    logic [6:0] dz;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dz_cfg_reg <= 7'd16;
        else if (cfg_write_en)
            dz_cfg_reg <= cfg_write_data;
    end

    assign dz = (dz_cfg_reg > DZ_MAX) ? DZ_MAX : dz_cfg_reg;

    // ---- latched input word ----
    logic        func_reg, player_reg, conn_reg, analog_reg, last_reg;
    logic [15:0] buttons_reg, word_reg;
    logic [7:0]  raw_reg [STICKS];
    logic [4:0]  idx_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg    <= func;
            player_reg  <= player;
            conn_reg    <= (pad_status == 8'd0);
            analog_reg  <= (pad_kind == KIND_ANALOG_A) || (pad_kind == KIND_ANALOG_B);
            buttons_reg <= buttons_raw;
            raw_reg[0]  <= left_x_raw;
            raw_reg[1]  <= left_y_raw;
            raw_reg[2]  <= right_x_raw;
            raw_reg[3]  <= right_y_raw;
            idx_reg     <= check_index;
            word_reg    <= check_word;
            last_reg    <= check_last;
        end
    end

    // ---- stick rescale ----
    logic [7:0]           raw_sel, mag_full, mag_dz;
    logic [6:0]           mag;
    logic                 neg;
    logic [DIV_NUM_W-1:0] div_num, div_quot;
    logic [DIV_DEN_W-1:0] div_den;
    logic                 div_done;
    logic [7:0]           stick_fin;
    logic [7:0]           stick_res_reg [STICKS];

    assign raw_sel  = raw_reg[cmd.stick_sel];
    assign neg      = !raw_sel[7];
    assign mag_full = neg ? (STICK_CENTER - raw_sel) : (raw_sel - STICK_CENTER);
    assign mag_dz   = (mag_full > {1'b0, dz}) ? (mag_full - {1'b0, dz}) : 8'd0;
    assign mag      = (mag_dz > STICK_MAX) ? STICK_MAX[6:0] : mag_dz[6:0];
    // mag * 127 as a shift and subtract
    assign div_num  = {mag, 7'd0} - DIV_NUM_W'(mag);
    assign div_den  = STICK_MAX[6:0] - dz;

    gic_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    // saturate: 128 for negative sticks, 127 for positive
    always_comb
    begin
        if (neg)
            stick_fin = 8'd0 - ((div_quot > DIV_NUM_W'(STICK_CENTER)) ?
                                STICK_CENTER : div_quot[7:0]);
        else
            stick_fin = (div_quot > DIV_NUM_W'(STICK_MAX)) ? STICK_MAX : div_quot[7:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_store)
            stick_res_reg[cmd.stick_sel] <= stick_fin;
    end

    // ---- per-player pad state ----
    logic [15:0]      held_now_reg  [PLAYERS];
    logic [7:0]       stick_now_reg [PLAYERS][STICKS];
    logic             pressed_latest_reg, match_running_reg;
    logic [PLY_W-1:0] p;
    logic [15:0]      old_held, new_held, pressed, released;
    logic [7:0]       old_stick [STICKS];
    logic [7:0]       new_stick [STICKS];
    logic             push;

    assign p        = PLY_W'(player_reg);
    assign old_held = held_now_reg[p];
    assign new_held = conn_reg ? ~buttons_reg : old_held;
    assign pressed  = new_held & ~old_held;
    assign released = old_held & ~new_held;
    assign push     = cmd.commit_poll && (pressed != 16'd0);

    always_comb
    begin
        for (int k = 0; k < STICKS; k++)
        begin
            old_stick[k] = stick_now_reg[p][k];
            new_stick[k] = (conn_reg && analog_reg) ? stick_res_reg[k] : old_stick[k];
        end
    end

    // ---- press history ring ----
    logic [15:0]      hist_mem [HISTORY_DEPTH];
    logic [PTR_W-1:0] head_reg, head_next, idx_ptr, rd_addr;
    logic [CNT_W-1:0] count_reg;
    logic [15:0]      hist_rd_reg;
    logic             in_count_reg, in_range_reg;
    logic             equal, run_after;

    assign head_next = (head_reg == PTR_W'(HISTORY_DEPTH - 1)) ? '0 : head_reg + PTR_W'(1);
    assign idx_ptr   = PTR_W'(idx_reg);
    assign rd_addr   = (head_reg >= idx_ptr) ? (head_reg - idx_ptr) :
                       PTR_W'({1'b0, head_reg} + (PTR_W + 1)'(HISTORY_DEPTH) - {1'b0, idx_ptr});

    always_ff @(posedge clk)
    begin
        if (push)
            hist_mem[head_next] <= pressed;
        if (cmd.mem_read)
        begin
            hist_rd_reg  <= hist_mem[rd_addr];
            in_count_reg <= CMP_W'(idx_reg) < CMP_W'(count_reg);
            in_range_reg <= CMP_W'(idx_reg) < CMP_W'(HISTORY_DEPTH);
        end
    end

    // entries never pushed read as zero
    assign equal     = in_range_reg && (in_count_reg ? (hist_rd_reg == word_reg)
                                                     : (word_reg == 16'd0));
    assign run_after = match_running_reg && equal;

    // ---- state update ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PLAYERS; i++)
            begin
                held_now_reg[i] <= '0;
                for (int k = 0; k < STICKS; k++)
                    stick_now_reg[i][k] <= '0;
            end
            pressed_latest_reg <= 1'b0;
            match_running_reg  <= 1'b1;
            head_reg           <= '0;
            count_reg          <= '0;
        end
        else
        begin
            if (cmd.commit_poll)
            begin
                held_now_reg[p] <= new_held;
                for (int k = 0; k < STICKS; k++)
                    stick_now_reg[p][k] <= new_stick[k];
                if (conn_reg)
                    pressed_latest_reg <= (pressed != 16'd0);
            end
            if (push)
            begin
                head_reg <= head_next;
                if (count_reg != CNT_W'(HISTORY_DEPTH))
                    count_reg <= count_reg + CNT_W'(1);
            end
            if (cmd.commit_check)
                match_running_reg <= last_reg ? 1'b1 : run_after;
        end
    end

    // ---- result register ----
    logic        out_valid_reg;
    logic        out_load;
    logic [15:0] held_o_reg, pressed_o_reg, released_o_reg;
    logic [7:0]  stick_o_reg [STICKS];
    logic [7:0]  delta_o_reg [STICKS];
    logic        match_o_reg;

    assign out_load = cmd.commit_poll || (cmd.commit_check && last_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit_poll)
        begin
            held_o_reg     <= new_held;
            pressed_o_reg  <= pressed;
            released_o_reg <= released;
            for (int k = 0; k < STICKS; k++)
            begin
                stick_o_reg[k] <= new_stick[k];
                delta_o_reg[k] <= new_stick[k] - old_stick[k];
            end
            match_o_reg <= 1'b0;
        end
        else if (cmd.commit_check && last_reg)
        begin
            held_o_reg     <= '0;
            pressed_o_reg  <= '0;
            released_o_reg <= '0;
            for (int k = 0; k < STICKS; k++)
            begin
                stick_o_reg[k] <= '0;
                delta_o_reg[k] <= '0;
            end
            match_o_reg <= run_after && pressed_latest_reg;
        end
    end

    assign out_valid      = out_valid_reg;
    assign held_mask      = held_o_reg;
    assign pressed_mask   = pressed_o_reg;
    assign released_mask  = released_o_reg;
    assign left_x         = stick_o_reg[0];
    assign left_y         = stick_o_reg[1];
    assign right_x        = stick_o_reg[2];
    assign right_y        = stick_o_reg[3];
    assign left_x_delta   = delta_o_reg[0];
    assign left_y_delta   = delta_o_reg[1];
    assign right_x_delta  = delta_o_reg[2];
    assign right_y_delta  = delta_o_reg[3];
    assign sequence_match = match_o_reg;

    // ---- status ----
    assign status.is_check    = (func_reg == FUNC_CHECK);
    assign status.player_ok   = CMP_W'(player_reg) < CMP_W'(PLAYERS);
    assign status.analog_conn = conn_reg && analog_reg;
    assign status.check_last  = last_reg;
    assign status.div_done    = div_done;
    assign status.out_free    = !out_valid_reg || out_ready;

endmodule
`default_nettype wire

[sv/gamepad_input_conditioner.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gamepad_input_conditioner
// Two-pad input conditioner: button edge masks, stick deadzone rescale,
// shared press history and history sequence compare.
// ----------------------------------------------------------------------------
// Rescale: an analog poll passes its 4 sticks through one shared 14-step
//   restoring divider in turn; digital or disconnected polls and compare
//   elements skip the divider.
// Flow: one word at a time; a new word is taken when the sequencer is back
//   in idle, even while the previous result still waits on out_ready.
// Reset: rst_n clears pad state, history fill count and match state at once;
//   deadzone returns to 16. No clearing pass.
// ----------------------------------------------------------------------------
module gamepad_input_conditioner #(
    parameter int HISTORY_DEPTH = 32,   // press history words, 2..256
    parameter int PLAYERS       = 2     // pad ports, 1..8
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    // configuration: stick_deadzone
    input  wire logic         cfg_write_en,
    input  wire logic [6:0]   cfg_write_data,
    // input word
    input  wire logic         in_valid,
    output logic              in_ready,
    input  wire logic         func,
    input  wire logic         player,
    input  wire logic [7:0]   pad_status,
    input  wire logic [7:0]   pad_kind,
    input  wire logic [15:0]  buttons_raw,
    input  wire logic [7:0]   left_x_raw,
    input  wire logic [7:0]   left_y_raw,
    input  wire logic [7:0]   right_x_raw,
    input  wire logic [7:0]   right_y_raw,
    input  wire logic [4:0]   check_index,
    input  wire logic [15:0]  check_word,
    input  wire logic         check_last,
    // result word
    output logic              out_valid,
    input  wire logic         out_ready,
    output logic [15:0]       held_mask,
    output logic [15:0]       pressed_mask,
    output logic [15:0]       released_mask,
    output logic signed [7:0] left_x,
    output logic signed [7:0] left_y,
    output logic signed [7:0] right_x,
    output logic signed [7:0] right_y,
    output logic signed [7:0] left_x_delta,
    output logic signed [7:0] left_y_delta,
    output logic signed [7:0] right_x_delta,
    output logic signed [7:0] right_y_delta,
    output logic              sequence_match
);
    import gic_pkg::*;

    cmd_t    cmd;
    status_t status;

    // sequencer: dispatch, per-stick divide steps, commit when output is free or no result is due
    gic_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // datapath: word latch, rescale + divider, pad state, history ring,
    // output register (holds the result while the next word is taken)
    gic_datapath #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .PLAYERS       (PLAYERS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .func           (func),
        .player         (player),
        .pad_status     (pad_status),
        .pad_kind       (pad_kind),
        .buttons_raw    (buttons_raw),
        .left_x_raw     (left_x_raw),
        .left_y_raw     (left_y_raw),
        .right_x_raw    (right_x_raw),
        .right_y_raw    (right_y_raw),
        .check_index    (check_index),
        .check_word     (check_word),
        .check_last     (check_last),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .held_mask      (held_mask),
        .pressed_mask   (pressed_mask),
        .released_mask  (released_mask),
        .left_x         (left_x),
        .left_y         (left_y),
        .right_x        (right_x),
        .right_y        (right_y),
        .left_x_delta   (left_x_delta),
        .left_y_delta   (left_y_delta),
        .right_x_delta  (right_x_delta),
        .right_y_delta  (right_y_delta),
        .sequence_match (sequence_match)
    );

endmodule
`default_nettype wire

[tb/gamepad_input_conditioner_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gamepad_input_conditioner_test
// Self-checking bench for the two-pad input conditioner. Poll and compare
// words go in over a valid/ready channel. A predictor of button
// edges, stick deadzone rescale, press history and sequence compare builds
// the expected result words. A checker matches each result word in order.
// ----------------------------------------------------------------------------
module gamepad_input_conditioner_test;

    import gic_pkg::*;

    // settle wait, longer than the longest block latency (analog poll)
    localparam int SETTLE_CYCLES = 100;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int PADS          = 2;
    localparam int LOG_DEPTH     = 32;

    // one input word, as the sender holds it
    typedef struct packed {
        logic        func;
        logic        player;
        logic [7:0]  status;
        logic [7:0]  kind;
        logic [15:0] buttons;
        logic [7:0]  lx;
        logic [7:0]  ly;
        logic [7:0]  rx;
        logic [7:0]  ry;
        logic [4:0]  idx;
        logic [15:0] word;
        logic        last;
    } pad_word_t;

    // one result word; field order matches the output port order
    typedef struct packed {
        logic [15:0] held;
        logic [15:0] pressed;
        logic [15:0] released;
        logic [7:0]  lx;
        logic [7:0]  ly;
        logic [7:0]  rx;
        logic [7:0]  ry;
        logic [7:0]  dlx;
        logic [7:0]  dly;
        logic [7:0]  drx;
        logic [7:0]  dry;
        logic        seq_match;
    } pad_report_t;

    // ------------------------------------------------------------------------
    // DUT hookup; every input starts at a known value
    // ------------------------------------------------------------------------
    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        cfg_write_en   = 1'b0;
    logic [6:0]  cfg_write_data = '0;
    logic        in_valid       = 1'b0;
    logic        out_ready      = 1'b0;
    pad_word_t   drive_word     = '0;

    logic              in_ready;
    logic              out_valid;
    logic [15:0]       held_mask;
    logic [15:0]       pressed_mask;
    logic [15:0]       released_mask;
    logic signed [7:0] left_x;
    logic signed [7:0] left_y;
    logic signed [7:0] right_x;
    logic signed [7:0] right_y;
    logic signed [7:0] left_x_delta;
    logic signed [7:0] left_y_delta;
    logic signed [7:0] right_x_delta;
    logic signed [7:0] right_y_delta;
    logic              sequence_match;

    gamepad_input_conditioner u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .func           (drive_word.func),
        .player         (drive_word.player),
        .pad_status     (drive_word.status),
        .pad_kind       (drive_word.kind),
        .buttons_raw    (drive_word.buttons),
        .left_x_raw     (drive_word.lx),
        .left_y_raw     (drive_word.ly),
        .right_x_raw    (drive_word.rx),
        .right_y_raw    (drive_word.ry),
        .check_index    (drive_word.idx),
        .check_word     (drive_word.word),
        .check_last     (drive_word.last),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .held_mask      (held_mask),
        .pressed_mask   (pressed_mask),
        .released_mask  (released_mask),
        .left_x         (left_x),
        .left_y         (left_y),
        .right_x        (right_x),
        .right_y        (right_y),
        .left_x_delta   (left_x_delta),
        .left_y_delta   (left_y_delta),
        .right_x_delta  (right_x_delta),
        .right_y_delta  (right_y_delta),
        .sequence_match (sequence_match)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Predictor state: mirrors the pad, stick, history and compare state
    // ------------------------------------------------------------------------
    logic [6:0]  deadzone_setting = 7'd16;
    logic [15:0] pad_held      [PADS]      = '{default: '0};
    logic [15:0] pad_held_prev [PADS]      = '{default: '0};
    logic [7:0]  stick_cur     [PADS*4]    = '{default: '0};
    logic [7:0]  stick_prev    [PADS*4]    = '{default: '0};
    logic [15:0] press_log     [LOG_DEPTH] = '{default: '0};
    bit          last_poll_pressed = 1'b0;
    bit          compare_ok        = 1'b1;

    pad_report_t expected_reports[$];

    int mismatches     = 0;
    int words_sent     = 0;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // Deadzone rescale of one raw stick byte. Deadzone 127 acts as 126 so
    // the divisor stays nonzero; the rescaled magnitude saturates at 127
    // on the positive side and at 128 on the negative side.
    function automatic logic [7:0] deadzone_rescale(logic [7:0] raw);
        int unsigned dz;
        int unsigned mag;
        bit          neg;
        dz  = (deadzone_setting > DZ_MAX) ? int'(DZ_MAX) : int'(deadzone_setting);
        neg = raw < STICK_CENTER;
        mag = neg ? int'(STICK_CENTER) - int'(raw) : int'(raw) - int'(STICK_CENTER);
        mag = (mag > dz) ? mag - dz : 0;
        if (mag > int'(STICK_MAX))
            mag = int'(STICK_MAX);
        mag = mag * int'(STICK_MAX) / (int'(STICK_MAX) - dz);
        if (neg)
        begin
            if (mag > 128)
                mag = 128;
            return 8'(256 - mag);
        end
        if (mag > int'(STICK_MAX))
            mag = int'(STICK_MAX);
        return 8'(mag);
    endfunction

    // Advances the predicted state by one accepted word. Returns 1 with the
    // expected result word when the word produces one.
    function automatic bit predict_conditioner(pad_word_t w, output pad_report_t rep);
        logic [15:0] pressed;
        int          p;
        int          b;
        rep = '0;
        if (w.func == FUNC_POLL)
        begin
            p = int'(w.player);
            b = p * 4;
            // previous values always age, even for a disconnected pad
            pad_held_prev[p] = pad_held[p];
            for (int k = 0; k < 4; k++)
                stick_prev[b + k] = stick_cur[b + k];
            if (w.status == 8'h00)
            begin
                pad_held[p]       = ~w.buttons;
                pressed           = pad_held[p] & ~pad_held_prev[p];
                last_poll_pressed = (pressed != 16'h0000);
                if (pressed != 16'h0000)
                begin
                    for (int h = LOG_DEPTH - 1; h > 0; h--)
                        press_log[h] = press_log[h - 1];
                    press_log[0] = pressed;
                end
                // digital pads leave the sticks where they were
                if (w.kind == KIND_ANALOG_A || w.kind == KIND_ANALOG_B)
                begin
                    stick_cur[b]     = deadzone_rescale(w.lx);
                    stick_cur[b + 1] = deadzone_rescale(w.ly);
                    stick_cur[b + 2] = deadzone_rescale(w.rx);
                    stick_cur[b + 3] = deadzone_rescale(w.ry);
                end
            end
            rep.held     = pad_held[p];
            rep.pressed  = pad_held[p] & ~pad_held_prev[p];
            rep.released = pad_held_prev[p] & ~pad_held[p];
            rep.lx       = stick_cur[b];
            rep.ly       = stick_cur[b + 1];
            rep.rx       = stick_cur[b + 2];
            rep.ry       = stick_cur[b + 3];
            rep.dlx      = stick_cur[b]     - stick_prev[b];
            rep.dly      = stick_cur[b + 1] - stick_prev[b + 1];
            rep.drx      = stick_cur[b + 2] - stick_prev[b + 2];
            rep.dry      = stick_cur[b + 3] - stick_prev[b + 3];
            return 1'b1;
        end
        if (press_log[w.idx] != w.word)
            compare_ok = 1'b0;
        if (w.last)
        begin
            rep.seq_match = compare_ok && last_poll_pressed;
            compare_ok    = 1'b1;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------------
    // Word builders; fields the block ignores carry random bits
    // ------------------------------------------------------------------------
    function automatic pad_word_t poll_word(bit p, logic [7:0] status, logic [7:0] kind,
                                            logic [15:0] buttons, logic [7:0] lx,
                                            logic [7:0] ly, logic [7:0] rx, logic [7:0] ry);
        pad_word_t w;
        w         = pad_word_t'({$urandom, $urandom, $urandom, $urandom});
        w.func    = FUNC_POLL;
        w.player  = p;
        w.status  = status;
        w.kind    = kind;
        w.buttons = buttons;
        w.lx      = lx;
        w.ly      = ly;
        w.rx      = rx;
        w.ry      = ry;
        return w;
    endfunction

    function automatic pad_word_t compare_word(logic [4:0] idx, logic [15:0] word, bit last);
        pad_word_t w;
        w      = pad_word_t'({$urandom, $urandom, $urandom, $urandom});
        w.func = FUNC_CHECK;
        w.idx  = idx;
        w.word = word;
        w.last = last;
        return w;
    endfunction

    // stick values biased toward the deadzone edge and the center
    function automatic logic [7:0] rand_stick();
        int off;
        off = int'(deadzone_setting) + int'($urandom_range(2)) - 1;
        case ($urandom_range(3))
            0:       return ($urandom_range(1) == 1) ? 8'(128 + off) : 8'(128 - off);
            1:       return STICK_CENTER + 8'($urandom_range(2)) - 8'd1;
            default: return 8'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Shared sender: optional idle gap, hold valid until taken, then predict.
    // Valid is left high on return; an idle gap in the next call or a pause lowers it, so
    // in_valid never sees two updates in one step.
    // ------------------------------------------------------------------------
    task automatic send_word(pad_word_t w);
        pad_report_t rep;
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        drive_word <= w;
        in_valid   <= 1'b1;
        do @(posedge clk); while (!in_ready);
        if (predict_conditioner(w, rep))
            expected_reports.push_back(rep);
        words_sent++;
    endtask

    // sender backs off until every expected word is in, then lets the block
    // finish any compare element that had no result
    task automatic pause_until_drained();
        in_valid <= 1'b0;
        while (expected_reports.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_deadzone(logic [6:0] dz);
        pause_until_drained();
        cfg_write_data <= dz;
        cfg_write_en   <= 1'b1;
        @(posedge clk);
        cfg_write_en     <= 1'b0;
        deadzone_setting  = dz;
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stalls at the phase's rate
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        out_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end

    // ------------------------------------------------------------------------
    // Checker: every taken result word against the oldest expectation
    // ------------------------------------------------------------------------
    pad_report_t want;
    pad_report_t seen;

    task automatic compare_field(string name, logic [15:0] exp_v, logic [15:0] got_v);
        if (got_v !== exp_v)
        begin
            $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, exp_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            seen = {held_mask, pressed_mask, released_mask, left_x, left_y, right_x,
                    right_y, left_x_delta, left_y_delta, right_x_delta, right_y_delta,
                    sequence_match};
            if (expected_reports.size() == 0)
            begin
                $display("%0t ns: unexpected result word, expected none, actual %h",
                         $time, seen);
                mismatches++;
            end
            else
            begin
                want = expected_reports.pop_front();
                compare_field("held_mask",      want.held,           seen.held);
                compare_field("pressed_mask",   want.pressed,        seen.pressed);
                compare_field("released_mask",  want.released,       seen.released);
                compare_field("left_x",         16'(want.lx),        16'(seen.lx));
                compare_field("left_y",         16'(want.ly),        16'(seen.ly));
                compare_field("right_x",        16'(want.rx),        16'(seen.rx));
                compare_field("right_y",        16'(want.ry),        16'(seen.ry));
                compare_field("left_x_delta",   16'(want.dlx),       16'(seen.dlx));
                compare_field("left_y_delta",   16'(want.dly),       16'(seen.dly));
                compare_field("right_x_delta",  16'(want.drx),       16'(seen.drx));
                compare_field("right_y_delta",  16'(want.dry),       16'(seen.dry));
                compare_field("sequence_match", 16'(want.seq_match), 16'(seen.seq_match));
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d result words outstanding",
                     cycle_count, expected_reports.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Held, pressed and released masks, analog vs digital pads, disconnected
    // pads aging their previous values, stick extremes at the reset deadzone.
    task automatic test_button_edges();
        send_word(poll_word(1'b0, 8'h00, KIND_ANALOG_A, 16'hFFFF,
                            8'd128, 8'd128, 8'd128, 8'd128));
        send_word(poll_word(1'b0, 8'h00, KIND_ANALOG_A, 16'h0000,
                            8'd0, 8'd255, 8'd1, 8'd254));
        // sticks right at and just past the deadzone edge
        send_word(poll_word(1'b0, 8'h00, KIND_ANALOG_B, 16'hFFFF,
                            8'd144, 8'd112, 8'd145, 8'd111));
        send_word(poll_word(1'b1, 8'h00, 8'h06, 16'h5555,
                            8'd0, 8'd0, 8'd255, 8'd255));
        send_word(poll_word(1'b1, 8'h80, KIND_ANALOG_A, 16'h0000,
                            8'd0, 8'd0, 8'd0, 8'd0));
        send_word(poll_word(1'b0, 8'hFF, KIND_ANALOG_B, 16'h0000,
                            8'd255, 8'd255, 8'd255, 8'd255));
        send_word(poll_word(1'b1, 8'h00, KIND_ANALOG_B, 16'hAAAA,
                            8'd200, 8'd50, 8'd127, 8'd129));
        // same buttons again: nothing newly pressed
        send_word(poll_word(1'b1, 8'h00, 8'hFF, 16'hAAAA,
                            8'd0, 8'd0, 8'd0, 8'd0));
    endtask

    // History compare: match needs a press on the latest poll, a mismatch
    // anywhere in the sequence spoils it, the deepest slot is reachable.
    task automatic test_history_compare();
        send_word(compare_word(5'd0, press_log[0], 1'b1));
        send_word(poll_word(1'b0, 8'h00, 8'h00, 16'hFFFE, 8'd0, 8'd0, 8'd0, 8'd0));
        send_word(compare_word(5'd0, press_log[0], 1'b0));
        send_word(compare_word(5'd1, press_log[1], 1'b0));
        send_word(compare_word(5'd2, press_log[2], 1'b1));
        send_word(compare_word(5'd31, press_log[31], 1'b1));
        send_word(compare_word(5'd0, ~press_log[0], 1'b0));
        send_word(compare_word(5'd1, press_log[1], 1'b1));
        send_word(compare_word(5'd1, press_log[1], 1'b1));
        send_word(compare_word(5'd31, 16'hFFFF, 1'b1));
    endtask

    // Deadzone at both ends of its range and the out-of-range 127.
    task automatic test_deadzone_extremes();
        set_deadzone(7'd0);
        send_word(poll_word(1'b0, 8'h00, KIND_ANALOG_A, 16'h0F0F,
                            8'd0, 8'd255, 8'd127, 8'd129));
        set_deadzone(DZ_MAX);
        send_word(poll_word(1'b0, 8'h00, KIND_ANALOG_A, 16'hF0F0,
                            8'd0, 8'd255, 8'd1, 8'd254));
        set_deadzone(7'd127);
        send_word(poll_word(1'b1, 8'h00, KIND_ANALOG_B, 16'h0000,
                            8'd0, 8'd255, 8'd2, 8'd253));
    endtask

    // One play sequence: polls then a compare run built from the predicted
    // history. Random traffic mixes these with raw noise words and occasional full pauses.
    task automatic play_episode();
        int          polls;
        int          len;
        int          idx_i;
        bit          p;
        logic [7:0]  kind;
        logic [7:0]  status;
        logic [15:0] buttons;
        polls = $urandom_range(1, 3);
        for (int i = 0; i < polls; i++)
        begin
            p = 1'($urandom_range(1));
            case ($urandom_range(3))
                0:       kind = KIND_ANALOG_A;
                1:       kind = KIND_ANALOG_B;
                default: kind = 8'($urandom);
            endcase
            status  = ($urandom_range(9) == 0) ? 8'($urandom_range(1, 255)) : 8'h00;
            buttons = ($urandom_range(4) == 0) ? ~pad_held[p] : 16'($urandom);
            send_word(poll_word(p, status, kind, buttons,
                                rand_stick(), rand_stick(), rand_stick(), rand_stick()));
        end
        len = $urandom_range(1, 4);
        for (int i = 0; i < len; i++)
        begin
            idx_i = ($urandom_range(3) == 0) ? $urandom_range(31) : i;
            send_word(compare_word(5'(idx_i),
                                   ($urandom_range(9) == 0) ? 16'($urandom) : press_log[idx_i],
                                   i == len - 1));
        end
    endtask

    task automatic test_random_traffic(int idle_pct, int stall_pct, logic [6:0] dz, int count);
        int target;
        pad_word_t noise;
        set_deadzone(dz);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        target = words_sent + count;
        while (words_sent < target)
        begin
            if ($urandom_range(9) < 7)
                play_episode();
            else
            begin
                noise = pad_word_t'({$urandom, $urandom, $urandom, $urandom});
                if ($urandom_range(1) == 1)
                    noise.status = 8'h00;
                send_word(noise);
            end
            if ($urandom_range(39) == 0)
                pause_until_drained();
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_button_edges();
        test_history_compare();
        test_deadzone_extremes();

        // no idling / sender idle / receiver stall / both
        test_random_traffic(0,  0,  7'd0,   225);
        test_random_traffic(55, 0,  DZ_MAX, 225);
        test_random_traffic(0,  55, 7'($urandom_range(1, 125)), 225);
        test_random_traffic(23, 23, 7'd127, 225);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        pause_until_drained();

        if (mismatches == 0 && expected_reports.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

[gamepad_input_conditioner.f]
sv/gic_pkg.sv
sv/gic_divider.sv
sv/gic_ctrl.sv
sv/gic_datapath.sv
sv/gamepad_input_conditioner.sv
tb/gamepad_input_conditioner_test.sv
